[hw/rtl/qdec_pkg.sv]
// Shared constants, types and the transition table of the quadrature decoder.
package qdec_pkg;

  localparam int unsigned TIME_WIDTH  = 32;
  localparam int unsigned COUNT_WIDTH = 32;

  // Wide enough to compare a time difference against the 32-bit pause length.
  localparam int unsigned CMP_WIDTH   = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  localparam int unsigned TIME_US_W   = 32;
  localparam int unsigned PAUSE_W     = 32;
  localparam int unsigned FAST_INC_W  = 8;
  localparam int unsigned CHANGE_W    = 9;
  localparam int unsigned POSITION_W  = 32;
  localparam int unsigned ACCUM_W     = 4;

  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAUSE_LENGTH   = 8'd0,
    CFG_FAST_INCREMENT = 8'd1
  } cfg_idx_e;

  typedef logic [TIME_WIDTH-1:0]         time_t;
  typedef logic signed [COUNT_WIDTH-1:0] count_t;
  typedef logic signed [ACCUM_W-1:0]     accum_t;
  typedef logic signed [CHANGE_W-1:0]    change_t;

  // Indexed by {previous A, previous B, current A, current B}.
  localparam logic signed [1:0] TRANS_TAB [16] = '{
    2'sd0,  -2'sd1,  2'sd1,  2'sd0,
    2'sd1,   2'sd0,  2'sd0, -2'sd1,
   -2'sd1,   2'sd0,  2'sd0,  2'sd1,
    2'sd0,   2'sd1, -2'sd1,  2'sd0
  };

  localparam accum_t ACCUM_UP   = 4'sd4;
  localparam accum_t ACCUM_DOWN = -4'sd4;

endpackage

[hw/rtl/qdec_if.sv]
// Valid/ready channel interfaces for samples, results and configuration writes.
interface qdec_in_if;
  logic                             valid;
  logic                             ready;
  logic                             pin_a;
  logic                             pin_b;
  logic [qdec_pkg::TIME_US_W-1:0]   time_us;

  modport source (output valid, pin_a, pin_b, time_us, input ready);
  modport sink   (input valid, pin_a, pin_b, time_us, output ready);
endinterface

interface qdec_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [qdec_pkg::CHANGE_W-1:0]    change;
  logic signed [qdec_pkg::POSITION_W-1:0]  position;

  modport source (output valid, change, position, input ready);
  modport sink   (input valid, change, position, output ready);
endinterface

interface qdec_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [qdec_pkg::CFG_IDX_W-1:0]    index;
  logic [qdec_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/quadrature_decoder_accel.sv]
// Quadrature encoder decoder with detent acceleration: top level.
//
// One pin sample per beat in, one result per beat out. Each sample is captured in an
// input register and decoded into the result register once that is free: transition
// table lookup, step accumulation, the detent check at +4/-4, and a compare of the
// time since the last same-direction detent against pause_length, which turns a +/-1
// detent into +/-fast_increment. Throughput is one sample per cycle, limited only by
// the single decode stage and output backpressure. The position counter wraps.
// Configuration writes take effect on the next decoded sample.
module quadrature_decoder_accel (
  input  logic             clk_i,
  input  logic             rst_ni,
  qdec_in_if.sink          in_i,
  qdec_out_if.source       out_o,
  qdec_cfg_if.sink         cfg_i
);

  // configuration
  logic [qdec_pkg::PAUSE_W-1:0]    pause_q;
  logic [qdec_pkg::FAST_INC_W-1:0] fast_inc_q;

  // input stage
  logic                 s1_valid_q;
  logic                 s1_a_q;
  logic                 s1_b_q;
  qdec_pkg::time_t      s1_time_q;

  // decoder state
  logic [1:0]           prev_q;
  qdec_pkg::accum_t     acc_q;
  qdec_pkg::time_t      last_up_q;
  qdec_pkg::time_t      last_down_q;
  qdec_pkg::count_t     count_q;

  // result register
  logic                 out_valid_q;
  qdec_pkg::change_t    change_q;
  logic signed [qdec_pkg::POSITION_W-1:0] position_q;

  logic                 out_free;
  logic                 out_load;
  logic                 in_fire;

  logic [3:0]           tab_idx;
  qdec_pkg::accum_t     acc_sum;
  logic                 det_up;
  logic                 det_down;
  qdec_pkg::time_t      diff;
  logic                 fast;
  qdec_pkg::change_t    mag;
  qdec_pkg::change_t    change_d;
  qdec_pkg::accum_t     acc_d;
  qdec_pkg::count_t     count_d;

  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // decode
  assign tab_idx  = {prev_q, s1_a_q, s1_b_q};
  assign acc_sum  = acc_q + qdec_pkg::ACCUM_W'(qdec_pkg::TRANS_TAB[tab_idx]);
  assign det_up   = (acc_sum == qdec_pkg::ACCUM_UP);
  assign det_down = (acc_sum == qdec_pkg::ACCUM_DOWN);
  assign diff     = s1_time_q - (det_up ? last_up_q : last_down_q);
  assign fast     = qdec_pkg::CMP_WIDTH'(diff) < qdec_pkg::CMP_WIDTH'(pause_q);
  assign mag      = fast ? qdec_pkg::change_t'({1'b0, fast_inc_q})
                         : qdec_pkg::change_t'(1);

  always_comb begin
    change_d = '0;
    acc_d    = acc_sum;
    if (det_up) begin
      change_d = mag;
      acc_d    = '0;
    end else if (det_down) begin
      change_d = -mag;
      acc_d    = '0;
    end
  end

  assign count_d = count_q + qdec_pkg::COUNT_WIDTH'(change_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q    <= qdec_pkg::PAUSE_W'(25000);
      fast_inc_q <= qdec_pkg::FAST_INC_W'(10);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == qdec_pkg::CFG_PAUSE_LENGTH) begin
        pause_q <= cfg_i.data[qdec_pkg::PAUSE_W-1:0];
      end
      if (cfg_i.index == qdec_pkg::CFG_FAST_INCREMENT) begin
        fast_inc_q <= cfg_i.data[qdec_pkg::FAST_INC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_a_q    <= in_i.pin_a;
      s1_b_q    <= in_i.pin_b;
      s1_time_q <= qdec_pkg::TIME_WIDTH'(in_i.time_us);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= 2'b11;
      acc_q       <= '0;
      last_up_q   <= '0;
      last_down_q <= '0;
      count_q     <= '0;
    end else if (out_load) begin
      prev_q  <= {s1_a_q, s1_b_q};
      acc_q   <= acc_d;
      count_q <= count_d;
      if (det_up) begin
        last_up_q <= s1_time_q;
      end
      if (det_down) begin
        last_down_q <= s1_time_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      change_q   <= change_d;
      position_q <= qdec_pkg::POSITION_W'(count_d);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.change   = change_q;
  assign out_o.position = position_q;

  // accumulator never rests at a detent value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q != qdec_pkg::ACCUM_UP && acc_q != qdec_pkg::ACCUM_DOWN
    && acc_q != 4'sd5 && acc_q != -4'sd5)
    else $error("step accumulator out of range");

  // a nonzero change always comes with a cleared accumulator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (change_q == '0) || (acc_q == '0))
    else $error("detent without accumulator clear");

  // counter moves by exactly the reported change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> count_q == $past(count_q) + qdec_pkg::COUNT_WIDTH'(change_q))
    else $error("position counter mismatch");

  // an empty pipeline always takes a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s1_valid_q && !out_valid_q) |-> in_i.ready)
    else $error("idle decoder stalls input");

endmodule

[tb/sv/quadrature_decoder_accel_tb.sv]
// Testbench for quadrature_decoder_accel: predicts every detent result and checks it.
module quadrature_decoder_accel_tb;
  import qdec_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_TIME   = 2_000_000;
  localparam int PHASE_ITEMS  = 200;

  localparam logic [PAUSE_W-1:0]    PAUSE_RESET    = 32'd25000;
  localparam logic [FAST_INC_W-1:0] FAST_INC_RESET = 8'd10;

  // Step from {previous A, previous B, current A, current B}.
  localparam int STEP_OF_TRANSITION [16] = '{
    0, -1,  1,  0,
    1,  0,  0, -1,
   -1,  0,  0,  1,
    0,  1, -1,  0
  };

  typedef struct {
    change_t change;
    count_t  position;
  } move_t;

  typedef enum int {
    RX_STREAM,
    RX_MOSTLY,
    RX_SPARSE,
    RX_TOGGLE
  } stall_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  qdec_in_if  sample_bus ();
  qdec_out_if result_bus ();
  qdec_cfg_if cfg_bus ();

  quadrature_decoder_accel dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_bus),
    .out_o  (result_bus),
    .cfg_i  (cfg_bus)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Decoder state as the block should hold it
  logic [1:0]            dec_prev_pins   = 2'b11;
  int                    dec_accum       = 0;
  time_t                 dec_last_up_us   = '0;
  time_t                 dec_last_down_us = '0;
  count_t                dec_position     = '0;
  logic [PAUSE_W-1:0]    dec_pause_len    = PAUSE_RESET;
  logic [FAST_INC_W-1:0] dec_fast_inc     = FAST_INC_RESET;

  move_t expected_moves [$];
  int    mismatch_count = 0;
  int    hold_request   = 0;
  time_t now_us         = '0;

  function automatic void decode_sample(input logic a, input logic b, input time_t t,
                                        output change_t chg, output count_t pos);
    logic [1:0] cur;
    time_t      gap_us;
    change_t    mag;
    cur = {a, b};
    dec_accum += STEP_OF_TRANSITION[{dec_prev_pins, cur}];
    dec_prev_pins = cur;
    mag = change_t'({1'b0, dec_fast_inc});
    chg = '0;
    if (dec_accum > 3) begin
      gap_us = t - dec_last_up_us;
      chg = (gap_us < dec_pause_len) ? mag : change_t'(1);
      dec_last_up_us = t;
      dec_accum = 0;
    end else if (dec_accum < -3) begin
      gap_us = t - dec_last_down_us;
      chg = (gap_us < dec_pause_len) ? -mag : -change_t'(1);
      dec_last_down_us = t;
      dec_accum = 0;
    end
    dec_position = dec_position + chg;
    pos = dec_position;
  endfunction

  // One gray-code step clockwise (3,1,0,2) or counterclockwise (3,2,0,1).
  function automatic logic [1:0] turn(input logic [1:0] p, input bit cw);
    if (cw) begin
      case (p)
        2'b11: return 2'b01;
        2'b01: return 2'b00;
        2'b00: return 2'b10;
        default: return 2'b11;
      endcase
    end
    case (p)
      2'b11: return 2'b10;
      2'b10: return 2'b00;
      2'b00: return 2'b01;
      default: return 2'b11;
    endcase
  endfunction

  // Leaves valid high on return; the caller lowers it only when a gap follows.
  task automatic send_sample(input logic a, input logic b, input time_t t);
    change_t chg;
    count_t  pos;
    sample_bus.valid   <= 1'b1;
    sample_bus.pin_a   <= a;
    sample_bus.pin_b   <= b;
    sample_bus.time_us <= t;
    do @(posedge clk_i); while (!sample_bus.ready);
    decode_sample(a, b, t, chg, pos);
    expected_moves.push_back('{chg, pos});
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    sample_bus.valid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx == CFG_PAUSE_LENGTH)
      dec_pause_len = data[PAUSE_W-1:0];
    else if (idx == CFG_FAST_INCREMENT)
      dec_fast_inc = data[FAST_INC_W-1:0];
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic turn_detent(input bit cw, input time_t t);
    logic [1:0] p;
    repeat (4) begin
      p = turn(dec_prev_pins, cw);
      send_sample(p[1], p[0], t);
    end
  endtask

  task automatic test_directed_decode();
    send_sample(1'b1, 1'b1, '0);
    turn_detent(1'b1, 32'd30000);       // slow up
    turn_detent(1'b1, 32'd30100);       // fast up
    turn_detent(1'b1, 32'd55100);       // gap equals pause: not accelerated
    turn_detent(1'b0, 32'hFFFF_FFF0);   // slow down
    turn_detent(1'b0, 32'h0000_0010);   // fast down across the time wrap
    // both pins flipping leaves the accumulator alone
    send_sample(1'b0, 1'b0, 32'h0000_0020);
    send_sample(1'b1, 1'b1, 32'h0000_0030);
    // bounce: one step forward, one back
    send_sample(1'b0, 1'b1, 32'h0000_0040);
    send_sample(1'b1, 1'b1, 32'h0000_0050);
    drain_results();
  endtask

  task automatic test_register_extremes();
    write_register(CFG_PAUSE_LENGTH, 32'd0);
    write_register(CFG_FAST_INCREMENT, 32'd255);
    turn_detent(1'b1, 32'h0000_1000);
    drain_results();
    write_register(CFG_PAUSE_LENGTH, 32'hFFFF_FFFF);
    turn_detent(1'b1, 32'h0000_1000);
    turn_detent(1'b0, 32'h8000_0000);
    turn_detent(1'b0, 32'h7FFF_FFFF);   // gap of all ones is not below the pause
    drain_results();
    write_register(CFG_FAST_INCREMENT, 32'hABCD_EF00);  // upper bits dropped: zero step
    turn_detent(1'b1, 32'h0000_2000);
    drain_results();
    write_register(CFG_IDX_W'($urandom_range(CFG_FAST_INCREMENT + 1, 255)), 32'd77);
    turn_detent(1'b1, 32'h0000_2001);
    drain_results();
    write_register(CFG_FAST_INCREMENT, 32'd1);
    turn_detent(1'b0, 32'h0000_2002);
    drain_results();
  endtask

  task automatic test_output_stall();
    logic [1:0] p;
    write_register(CFG_PAUSE_LENGTH, PAUSE_RESET);
    write_register(CFG_FAST_INCREMENT, FAST_INC_RESET);
    hold_request = HOLD_CYCLES;
    repeat (40) begin
      p = turn(dec_prev_pins, 1'b1);
      now_us += $urandom_range(0, 3000);
      send_sample(p[1], p[0], now_us);
    end
    drain_results();
  endtask

  task automatic test_random_rotation();
    int          phase;
    int          burst;
    int          sel;
    bit          cw;
    logic [1:0]  p;
    int unsigned max_step;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_register(CFG_PAUSE_LENGTH, PAUSE_RESET);
          write_register(CFG_FAST_INCREMENT, FAST_INC_RESET);
        end
        1: begin
          write_register(CFG_PAUSE_LENGTH, $urandom_range(100, 100000));
          write_register(CFG_FAST_INCREMENT, $urandom_range(1, 255));
        end
        2: begin
          write_register(CFG_PAUSE_LENGTH, $urandom());
          write_register(CFG_FAST_INCREMENT, $urandom());
        end
        default: begin
          write_register(CFG_PAUSE_LENGTH, $urandom_range(0, 5000));
          write_register(CFG_FAST_INCREMENT, 32'd255);
        end
      endcase
      // four quick steps should straddle the pause about half the time
      max_step = (dec_pause_len > 32'h1000_0000) ? 32'hFFFF_FFFF : dec_pause_len / 2 + 1;
      burst = $urandom_range(1, 40);
      cw = 1'($urandom_range(0, 1));
      repeat (PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (sel < 5)
          cw = ~cw;
        if (sel < 75)
          p = turn(dec_prev_pins, cw);
        else if (sel < 83)
          p = dec_prev_pins;
        else if (sel < 91)
          p = dec_prev_pins ^ 2'b11;
        else
          p = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0)
          now_us = $urandom();
        else
          now_us += $urandom_range(0, max_step);
        send_sample(p[1], p[0], now_us);
        burst--;
        if (burst == 0) begin
          pause_sender($urandom_range(1, 8));
          burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        end
      end
      drain_results();
    end
  endtask

  // Receiver: the stall pattern is redrawn after a random span; a hold request wins.
  initial begin
    stall_mode_e mode;
    int          span;
    int          hold_left;
    span = 0;
    hold_left = 0;
    mode = RX_STREAM;
    result_bus.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (span == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        span = $urandom_range(8, 80);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        case (mode)
          RX_STREAM: result_bus.ready <= 1'b1;
          RX_MOSTLY: result_bus.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: result_bus.ready <= ($urandom_range(0, 3) == 0);
          default:   result_bus.ready <= span[0];
        endcase
      end
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    move_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (expected_moves.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected beat: change %0d position %0d",
                   result_bus.change, result_bus.position);
        mismatch_count++;
      end else begin
        want = expected_moves.pop_front();
        if (result_bus.change !== want.change || result_bus.position !== want.position) begin
          if (mismatch_count < 10)
            $display("mismatch: change exp %0d got %0d, position exp %0d got %0d",
                     want.change, result_bus.change, want.position, result_bus.position);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    sample_bus.valid   <= 1'b0;
    sample_bus.pin_a   <= 1'b1;
    sample_bus.pin_b   <= 1'b1;
    sample_bus.time_us <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= CFG_PAUSE_LENGTH;
    cfg_bus.data       <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_decode();
    test_register_extremes();
    test_output_stall();
    test_random_rotation();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_moves.size() == 0)
      $display("[quadrature_decoder_accel] OK");
    else
      $display("[quadrature_decoder_accel] ERROR");
    $finish;
  end

  initial begin
    #LIMIT_TIME;
    $display("[quadrature_decoder_accel] ERROR");
    $finish;
  end

endmodule
